// ===== rtl/tle_pkg.sv =====
// Shared types and constants for the terminal line editor with history.
package tle_pkg;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_ERASE = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  // Command classes handed from the front end to the back end.
  typedef enum logic [2:0] {
    CMD_CHAR  = 3'd0,
    CMD_ERASE = 3'd1,
    CMD_ENTER = 3'd2,
    CMD_UP    = 3'd3,
    CMD_DOWN  = 3'd4
  } cmd_e;

  // Escape decoder phases.
  typedef enum logic [1:0] {
    ESC_NORMAL = 2'd0,
    ESC_SEEN   = 2'd1,
    ESC_CSI    = 2'd2
  } esc_e;

  // Byte codes.
  localparam logic [7:0] ChEsc     = 8'h1B;
  localparam logic [7:0] ChBracket = 8'h5B;
  localparam logic [7:0] ChDel     = 8'h7F;
  localparam logic [7:0] ChBs      = 8'h08;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChUp      = 8'h41;
  localparam logic [7:0] ChDown    = 8'h42;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTilde   = 8'h7E;

  // One classified command request.
  typedef struct packed {
    cmd_e       cmd;
    logic [6:0] ch;
  } cmd_t;

endpackage

// ===== rtl/tle_front.sv =====
// Front end: escape decoding and byte classification.
module tle_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [7:0]      rx_byte_i,
  output logic            full_o,
  output logic            cmd_valid_o,
  output tle_pkg::cmd_t   cmd_o,
  input  logic            cmd_full_i
);

  tle_pkg::esc_e esc_q, esc_d;
  logic          take;

  assign full_o = cmd_full_i;
  assign take   = push_i && !cmd_full_i;

  // Classify the byte and advance the escape decoder.
  always_comb begin
    esc_d       = esc_q;
    cmd_valid_o = 1'b0;
    cmd_o.cmd   = tle_pkg::CMD_CHAR;
    cmd_o.ch    = rx_byte_i[6:0];
    if (take) begin
      unique case (esc_q)
        tle_pkg::ESC_SEEN: begin
          esc_d = (rx_byte_i == tle_pkg::ChBracket) ? tle_pkg::ESC_CSI : tle_pkg::ESC_NORMAL;
        end
        tle_pkg::ESC_CSI: begin
          esc_d = tle_pkg::ESC_NORMAL;
          if (rx_byte_i == tle_pkg::ChUp) begin
            cmd_valid_o = 1'b1;
            cmd_o.cmd   = tle_pkg::CMD_UP;
          end else if (rx_byte_i == tle_pkg::ChDown) begin
            cmd_valid_o = 1'b1;
            cmd_o.cmd   = tle_pkg::CMD_DOWN;
          end
        end
        default: begin
          if (rx_byte_i == tle_pkg::ChEsc) begin
            esc_d = tle_pkg::ESC_SEEN;
          end else if (rx_byte_i == tle_pkg::ChCr || rx_byte_i == tle_pkg::ChLf) begin
            cmd_valid_o = 1'b1;
            cmd_o.cmd   = tle_pkg::CMD_ENTER;
          end else if (rx_byte_i == tle_pkg::ChBs || rx_byte_i == tle_pkg::ChDel) begin
            cmd_valid_o = 1'b1;
            cmd_o.cmd   = tle_pkg::CMD_ERASE;
          end else if (rx_byte_i >= tle_pkg::ChSpace && rx_byte_i <= tle_pkg::ChTilde) begin
            cmd_valid_o = 1'b1;
            cmd_o.cmd   = tle_pkg::CMD_CHAR;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= tle_pkg::ESC_NORMAL;
    end else begin
      esc_q <= esc_d;
    end
  end

endmodule

// ===== rtl/tle_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
module tle_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  tle_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          empty_o,
  output tle_pkg::cmd_t rdata_o
);

  tle_pkg::cmd_t mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rp_q];

  // Two-entry queue storage.
  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_i && !full_o) wp_q <= !wp_q;
      if (rd_i && !empty_o) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr_i && !full_o} - {1'b0, rd_i && !empty_o};
    end
  end

endmodule

// ===== rtl/tle_back.sv =====
// Back end: edit line, history ring and result sequencer.
module tle_back #(
  parameter int LINE_LEN   = 32,
  parameter int HIST_DEPTH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  tle_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          res_valid_o,
  output logic [1:0]    res_kind_o,
  output logic [6:0]    res_char_o,
  output logic          res_last_o,
  input  logic          res_ready_i
);

  localparam int LW = $clog2(LINE_LEN + 1);
  localparam int IW = $clog2(LINE_LEN);
  localparam int HW = $clog2(HIST_DEPTH + 1);
  localparam int SW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ERASE = 6'b000010,
    ST_RDREQ = 6'b000100,
    ST_ECHO  = 6'b001000,
    ST_LINE  = 6'b010000,
    ST_END   = 6'b100000
  } state_e;

  state_e         st_q, st_d;
  logic [6:0]     edit_q [LINE_LEN];
  logic [6:0]     hist_q [HIST_DEPTH * (2 ** IW)];
  logic [LW-1:0]  hlen_q [HIST_DEPTH];
  logic [LW-1:0]  elen_q, elen_d;
  logic [HW-1:0]  fill_q, fill_d, brw_q, brw_d;
  logic [SW-1:0]  head_q, head_d;          // ring slot of the oldest line
  logic [SW-1:0]  rslot_q, rslot_d;        // ring slot being recalled or stored
  logic [LW-1:0]  idx_q, idx_d, tgt_q, tgt_d;
  logic [6:0]     hrd_q;
  logic           hist_we;
  logic [6:0]     hist_wd;
  logic           edit_we;
  logic [IW-1:0]  edit_wa;
  logic [6:0]     edit_wd;
  logic           obuf_v_q;
  logic [1:0]     obuf_k_q;
  logic [6:0]     obuf_c_q;
  logic           obuf_l_q;
  logic           emit;
  logic [1:0]     emit_k;
  logic [6:0]     emit_c;
  logic           emit_l;
  logic           can_emit;
  logic [LW-1:0]  max_len;

  assign max_len  = LW'(LINE_LEN - 1);
  assign can_emit = !obuf_v_q || res_ready_i;

  // Ring slot for a logical history position.
  function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] head,
                                            input logic [HW-1:0] pos);
    logic [HW:0] s;
    s = {1'b0, head} + {1'b0, pos};
    if (s >= (HW+1)'(HIST_DEPTH)) s = s - (HW+1)'(HIST_DEPTH);
    return s[SW-1:0];
  endfunction

  // Sequencer.
  always_comb begin
    st_d = st_q; elen_d = elen_q; fill_d = fill_q; brw_d = brw_q; head_d = head_q;
    rslot_d = rslot_q; idx_d = idx_q; tgt_d = tgt_q;
    cmd_pop_o = 1'b0; emit = 1'b0; emit_k = tle_pkg::KIND_ECHO; emit_c = 7'd0; emit_l = 1'b0;
    hist_we = 1'b0; hist_wd = edit_q[idx_q[IW-1:0]];
    edit_we = 1'b0; edit_wa = elen_q[IW-1:0]; edit_wd = cmd_i.ch;
    unique case (st_q)
      ST_IDLE: begin
        if (!cmd_empty_i && can_emit) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.cmd)
            tle_pkg::CMD_CHAR: begin
              if (elen_q < max_len) begin
                edit_we = 1'b1;
                elen_d = elen_q + 1'b1;
                emit = 1'b1; emit_k = tle_pkg::KIND_ECHO; emit_c = cmd_i.ch; emit_l = 1'b1;
              end
            end
            tle_pkg::CMD_ERASE: begin
              if (elen_q != '0) begin
                elen_d = elen_q - 1'b1;
                emit = 1'b1; emit_k = tle_pkg::KIND_ERASE; emit_l = 1'b1;
              end
            end
            tle_pkg::CMD_ENTER: begin
              idx_d = '0;
              if (fill_q < HW'(HIST_DEPTH)) begin
                rslot_d = slot_of(head_q, fill_q);
              end else begin
                rslot_d = head_q;
              end
              st_d = (elen_q == '0) ? ST_END : ST_LINE;
            end
            tle_pkg::CMD_UP: begin
              if (brw_q != '0) begin
                brw_d = brw_q - 1'b1;
                rslot_d = slot_of(head_q, brw_q - 1'b1);
                tgt_d = '1;
                st_d = ST_ERASE;
              end
            end
            tle_pkg::CMD_DOWN: begin
              if (brw_q < fill_q) begin
                brw_d = brw_q + 1'b1;
                rslot_d = slot_of(head_q, brw_q + 1'b1);
                tgt_d = (brw_q + 1'b1 == fill_q) ? '0 : '1;
                st_d = ST_ERASE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ERASE: begin
        if (elen_q != '0) begin
          if (can_emit) begin
            elen_d = elen_q - 1'b1;
            emit = 1'b1; emit_k = tle_pkg::KIND_ERASE;
            emit_l = (elen_q == LW'(1)) && (tgt_q == '0 || hlen_q[rslot_q] == '0);
          end
        end else if (tgt_q == '0) begin
          st_d = ST_IDLE;
        end else begin
          tgt_d = (hlen_q[rslot_q] > max_len) ? max_len : hlen_q[rslot_q];
          idx_d = '0;
          st_d = (hlen_q[rslot_q] == '0) ? ST_IDLE : ST_RDREQ;
        end
      end
      ST_RDREQ: begin
        st_d = ST_ECHO;
      end
      ST_ECHO: begin
        if (can_emit) begin
          edit_we = 1'b1; edit_wa = idx_q[IW-1:0]; edit_wd = hrd_q;
          emit = 1'b1; emit_k = tle_pkg::KIND_ECHO; emit_c = hrd_q;
          emit_l = (idx_q + 1'b1 == tgt_q);
          idx_d = idx_q + 1'b1;
          if (idx_q + 1'b1 == tgt_q) begin
            elen_d = tgt_q;
            st_d = ST_IDLE;
          end else begin
            st_d = ST_RDREQ;
          end
        end
      end
      ST_LINE: begin
        if (can_emit) begin
          hist_we = 1'b1;
          emit = 1'b1; emit_k = tle_pkg::KIND_LINE; emit_c = edit_q[idx_q[IW-1:0]];
          idx_d = idx_q + 1'b1;
          if (idx_q + 1'b1 == elen_q) st_d = ST_END;
        end
      end
      ST_END: begin
        if (can_emit) begin
          emit = 1'b1; emit_k = tle_pkg::KIND_END; emit_l = 1'b1;
          if (elen_q != '0) begin
            if (fill_q < HW'(HIST_DEPTH)) begin
              fill_d = fill_q + 1'b1;
              brw_d = fill_q + 1'b1;
            end else begin
              head_d = slot_of(head_q, HW'(1));
              brw_d = fill_q;
            end
          end else begin
            brw_d = fill_q;
          end
          elen_d = '0;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Edit line and history memories.
  always_ff @(posedge clk_i) begin
    if (edit_we) edit_q[edit_wa] <= edit_wd;
    if (hist_we) hist_q[{rslot_q, idx_q[IW-1:0]}] <= hist_wd;
    if (st_q == ST_END && can_emit && elen_q != '0) hlen_q[rslot_q] <= elen_q;
    hrd_q <= hist_q[{rslot_q, idx_q[IW-1:0]}];
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      obuf_k_q <= emit_k; obuf_c_q <= emit_c; obuf_l_q <= emit_l;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; elen_q <= '0; fill_q <= '0; brw_q <= '0; head_q <= '0;
      rslot_q <= '0; idx_q <= '0; tgt_q <= '0; obuf_v_q <= 1'b0;
    end else begin
      st_q <= st_d; elen_q <= elen_d; fill_q <= fill_d; brw_q <= brw_d; head_q <= head_d;
      rslot_q <= rslot_d; idx_q <= idx_d; tgt_q <= tgt_d;
      if (emit) obuf_v_q <= 1'b1;
      else if (res_ready_i) obuf_v_q <= 1'b0;
    end
  end

  assign res_valid_o = obuf_v_q;
  assign res_kind_o  = obuf_k_q;
  assign res_char_o  = obuf_c_q;
  assign res_last_o  = obuf_l_q;

endmodule

// ===== rtl/terminal_line_editor_history.sv =====
// Top level of the terminal line editor with command history.
// Input side is a queue: drive rx_byte_i with push while full is low; one
// received terminal byte is one request. Output side is a queue: while
// empty is low, kind_o, char_out_o and last_o show the oldest result, and
// pop takes it. last_o marks the final result caused by one byte; bytes
// causing no result produce nothing.
// A byte is classified in the cycle it is pushed; escape, control and other
// dropped bytes end in the front end, the rest go to a two-entry command
// queue. The back end takes one command per cycle for printable and erase
// bytes while the result register is free; a line end or a history recall
// runs its sequencer, which reads the history memory before each recalled
// character.
// With the back end idle, the first result reaches the outputs through the
// command queue and the result register.
// Reset clears the edit line length, history fill, browse position and the
// escape decoder; the history memories need no clearing pass. When pop is
// held low the single result register fills, the sequencer waits, then the
// command queue fills and full rises; nothing is lost.
module terminal_line_editor_history #(
  parameter int LINE_LEN   = 32,
  parameter int HIST_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind_o,
  output logic [6:0] char_out_o,
  output logic       last_o
);

  logic          cmd_v, cmd_full, cmd_empty, cmd_pop, res_valid;
  tle_pkg::cmd_t cmd_in, cmd_out;

  tle_front u_front (
    .clk_i, .rst_ni, .push_i(push), .rx_byte_i, .full_o(full),
    .cmd_valid_o(cmd_v), .cmd_o(cmd_in), .cmd_full_i(cmd_full)
  );

  tle_cmd_fifo u_fifo (
    .clk_i, .rst_ni, .wr_i(cmd_v), .wdata_i(cmd_in), .full_o(cmd_full),
    .rd_i(cmd_pop), .empty_o(cmd_empty), .rdata_o(cmd_out)
  );

  tle_back #(.LINE_LEN(LINE_LEN), .HIST_DEPTH(HIST_DEPTH)) u_back (
    .clk_i, .rst_ni, .cmd_empty_i(cmd_empty), .cmd_i(cmd_out), .cmd_pop_o(cmd_pop),
    .res_valid_o(res_valid), .res_kind_o(kind_o), .res_char_o(char_out_o),
    .res_last_o(last_o), .res_ready_i(pop)
  );

  assign empty = !res_valid;

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(kind_o) && $stable(char_out_o) && $stable(last_o))
    else $error("stalled result changed");

  // Erase and line end results carry no character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (kind_o == tle_pkg::KIND_ERASE || kind_o == tle_pkg::KIND_END)
      |-> char_out_o == 7'd0)
    else $error("character on erase or line end");

  // A line end is always the final result of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o == tle_pkg::KIND_END |-> last_o)
    else $error("line end without last");

endmodule

// ===== sim/terminal_line_editor_history_tb.sv =====
// Testbench for the terminal line editor with history: directed and random byte streams.
module terminal_line_editor_history_tb;

  localparam int LineLen   = 32;
  localparam int HistDepth = 8;
  localparam int StallLimit = 4000;

  // One expected result.
  typedef struct packed {
    tle_pkg::kind_e kind;
    logic [6:0]     ch;
    logic           last;
  } result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] rx_byte_i;
  logic       empty;
  logic       pop;
  logic [1:0] kind_o;
  logic [6:0] char_out_o;
  logic       last_o;

  result_t   pending_results[$];
  int        error_count;
  int        idle_cycles;
  bit        pop_enable;

  // Predictor state.
  logic [6:0]     line_buf[LineLen];
  int             line_len;
  logic [6:0]     hist_text[HistDepth][LineLen];
  int             hist_len[HistDepth];
  int             hist_fill;
  int             browse;
  tle_pkg::esc_e  esc_phase;

  terminal_line_editor_history #(.LINE_LEN(LineLen), .HIST_DEPTH(HistDepth)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .rx_byte_i(rx_byte_i),
    .empty(empty), .pop(pop), .kind_o(kind_o), .char_out_o(char_out_o), .last_o(last_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic void add_result(ref result_t res[$], input tle_pkg::kind_e k,
                                     input logic [6:0] c);
    result_t r;
    r.kind = k;
    r.ch = c;
    r.last = 1'b0;
    res.push_back(r);
  endfunction

  function automatic void erase_line(ref result_t res[$]);
    while (line_len > 0) begin
      add_result(res, tle_pkg::KIND_ERASE, 7'd0);
      line_len--;
    end
  endfunction

  function automatic void recall_line(ref result_t res[$], input int slot);
    erase_line(res);
    for (int i = 0; i < hist_len[slot]; i++) begin
      line_buf[i] = hist_text[slot][i];
      add_result(res, tle_pkg::KIND_ECHO, line_buf[i]);
    end
    line_len = hist_len[slot];
  endfunction

  // Advance the editor model by one received byte and queue its results.
  task automatic predict_editor(input logic [7:0] c);
    result_t res[$];
    int slot;
    if (esc_phase == tle_pkg::ESC_SEEN) begin
      esc_phase = (c == tle_pkg::ChBracket) ? tle_pkg::ESC_CSI : tle_pkg::ESC_NORMAL;
    end else if (esc_phase == tle_pkg::ESC_CSI) begin
      esc_phase = tle_pkg::ESC_NORMAL;
      if (c == tle_pkg::ChUp && browse > 0) begin
        browse--;
        recall_line(res, browse);
      end else if (c == tle_pkg::ChDown && browse < hist_fill) begin
        browse++;
        if (browse == hist_fill) erase_line(res);
        else recall_line(res, browse);
      end
    end else if (c == tle_pkg::ChEsc) begin
      esc_phase = tle_pkg::ESC_SEEN;
    end else if (c == tle_pkg::ChCr || c == tle_pkg::ChLf) begin
      for (int i = 0; i < line_len; i++) add_result(res, tle_pkg::KIND_LINE, line_buf[i]);
      add_result(res, tle_pkg::KIND_END, 7'd0);
      if (line_len > 0) begin
        if (hist_fill < HistDepth) begin
          slot = hist_fill;
          hist_fill++;
        end else begin
          for (int s = 0; s < HistDepth - 1; s++) begin
            hist_text[s] = hist_text[s + 1];
            hist_len[s] = hist_len[s + 1];
          end
          slot = HistDepth - 1;
        end
        hist_text[slot] = line_buf;
        hist_len[slot] = line_len;
      end
      browse = hist_fill;
      line_len = 0;
    end else if (c == tle_pkg::ChBs || c == tle_pkg::ChDel) begin
      if (line_len > 0) begin
        line_len--;
        add_result(res, tle_pkg::KIND_ERASE, 7'd0);
      end
    end else if (c >= tle_pkg::ChSpace && c <= tle_pkg::ChTilde) begin
      if (line_len < LineLen - 1) begin
        line_buf[line_len] = c[6:0];
        line_len++;
        add_result(res, tle_pkg::KIND_ECHO, c[6:0]);
      end
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) pending_results.push_back(res[i]);
  endtask

  // Send one byte after a random gap; the prediction is made when it is accepted.
  // The request stays up after acceptance until the next byte or a gap replaces it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_editor(b);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_arrow(input logic [7:0] dir);
    send_byte(tle_pkg::ChEsc);
    send_byte(tle_pkg::ChBracket);
    send_byte(dir);
  endtask

  // Stop sending and wait until every expected result has been taken.
  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() > 0) @(negedge clk_i);
  endtask

  // Result drain with random stalls.
  initial begin
    int stall;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      stall = (pop_enable && $urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result kind=%0d char=%0h last=%0b", kind_o, char_out_o, last_o);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (kind_o !== exp_r.kind) begin
          $error("kind: expected %0d, actual %0d", exp_r.kind, kind_o);
          error_count++;
        end
        if (char_out_o !== exp_r.ch) begin
          $error("char_out: expected %0h, actual %0h", exp_r.ch, char_out_o);
          error_count++;
        end
        if (last_o !== exp_r.last) begin
          $error("last: expected %0b, actual %0b", exp_r.last, last_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("[terminal_line_editor_history] ERROR");
      $finish;
    end
  end

  task automatic test_editing();
    send_text("~ a");
    send_byte(tle_pkg::ChBs);
    send_byte(tle_pkg::ChDel);
    send_byte(tle_pkg::ChDel);
    send_byte(tle_pkg::ChDel);
    send_byte(tle_pkg::ChCr);
    send_text("0123456789abcdefghijklmnopqrstuvwx");
    send_byte(tle_pkg::ChLf);
  endtask

  task automatic test_escapes();
    send_byte(tle_pkg::ChEsc);
    send_byte(8'h41);
    send_arrow(8'h43);
    send_arrow(8'h44);
    send_byte(8'h00);
    send_byte(8'h1F);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_arrow(tle_pkg::ChDown);
  endtask

  task automatic test_history();
    for (int i = 0; i < HistDepth + 2; i++) begin
      send_byte(8'(8'h41 + i));
      send_byte(tle_pkg::ChCr);
    end
    wait_drained();
    for (int i = 0; i < HistDepth + 1; i++) send_arrow(tle_pkg::ChUp);
    for (int i = 0; i < HistDepth + 1; i++) send_arrow(tle_pkg::ChDown);
  endtask

  // Mostly well-formed lines and arrows, with noise mixed in.
  task automatic test_random();
    int sent;
    int sel;
    sent = 0;
    while (sent < 170) begin
      sel = $urandom_range(0, 19);
      if (sel < 10) begin
        send_byte(8'($urandom_range(tle_pkg::ChSpace, tle_pkg::ChTilde)));
        sent++;
      end else if (sel < 12) begin
        send_byte(($urandom_range(0, 1) != 0) ? tle_pkg::ChCr : tle_pkg::ChLf);
        sent++;
      end else if (sel < 13) begin
        send_byte(($urandom_range(0, 1) != 0) ? tle_pkg::ChBs : tle_pkg::ChDel);
        sent++;
      end else if (sel < 17) begin
        send_arrow(($urandom_range(0, 2) != 0) ? tle_pkg::ChUp : tle_pkg::ChDown);
        sent += 3;
      end else if (sel < 18) begin
        send_byte(tle_pkg::ChEsc);
        send_byte(8'($urandom_range(0, 255)));
        sent += 2;
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        sent++;
      end
      if (sent % 100 == 0) pop_enable = ~pop_enable;
    end
  endtask

  initial begin
    pop_enable = 1'b1;
    push = 1'b0;
    rx_byte_i = 8'h00;
    line_len = 0;
    hist_fill = 0;
    browse = 0;
    esc_phase = tle_pkg::ESC_NORMAL;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_editing();
    test_escapes();
    test_history();
    test_random();
    wait_drained();
    repeat (200) @(negedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[terminal_line_editor_history] OK");
    end else begin
      $display("[terminal_line_editor_history] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tle_pkg.sv
rtl/tle_front.sv
rtl/tle_cmd_fifo.sv
rtl/tle_back.sv
rtl/terminal_line_editor_history.sv
sim/terminal_line_editor_history_tb.sv
